// ===== design/trpr_pkg.sv =====
// ----------------------------------------------------------------------------
// trpr_pkg
// Shared types and constants for the tap pattern record/replay unit.
// ----------------------------------------------------------------------------
`default_nettype none

package trpr_pkg;

  localparam int PAT_W     = 64;   // pattern field width
  localparam int PAT_IDX_W = 6;    // bit index into a pattern word
  localparam int DEV_W     = 8;    // device id width
  localparam int SEQ_W     = 32;   // sequence number width
  localparam int PWM_W     = 16;   // PWM compare width
  localparam int OP_W      = 2;

  localparam int PATTERN_LEN_DEF = 64;
  localparam int NUM_DEVICES_DEF = 256;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
  localparam logic [OP_W-1:0] OP_RX    = 2'd2;

  localparam logic [DEV_W-1:0] TAP_PREAMBLE = 8'hF0;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_PWM_ON    = 2'd1;
  localparam logic [1:0] REG_START_SEQ = 2'd2;

  // classified item passed from front to back
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             level;
    logic             pairing;
    logic             preamble_ok;
    logic [DEV_W-1:0] slot;        // table slot: sender for rx, own entry otherwise
    logic [SEQ_W-1:0] rx_sequence;
    logic [PAT_W-1:0] rx_pattern;
  } item_t;

  // direct write of the own table entry from the register port
  typedef struct packed {
    logic             we;
    logic [DEV_W-1:0] slot;
    logic [SEQ_W-1:0] data;
  } seq_wr_t;

endpackage

`default_nettype wire

// ===== design/trpr_front.sv =====
// ----------------------------------------------------------------------------
// trpr_front
// Accepts items, maps device ids to table slots and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module trpr_front
  import trpr_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic             in_button_level,
  input  wire logic             in_pairing_active,
  input  wire logic [DEV_W-1:0] in_rx_preamble,
  input  wire logic [DEV_W-1:0] in_rx_device,
  input  wire logic [SEQ_W-1:0] in_rx_sequence,
  input  wire logic [PAT_W-1:0] in_rx_pattern,
  input  wire logic [DEV_W-1:0] own_id,
  output logic [DEV_W-1:0]      own_slot,
  output logic                  head_valid,
  output item_t                 head_item,
  input  wire logic             head_pop
);

  localparam int SLOT_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int IDS    = 1 << DEV_W;

  // id -> slot table, id modulo device count
  logic [SLOT_W-1:0] slot_lut [IDS];
  for (genvar g = 0; g < IDS; g++) begin : g_lut
    assign slot_lut[g] = SLOT_W'(g % NUM_DEVICES);
  end

  item_t             cls_item;
  item_t             q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;

  assign own_slot = DEV_W'(slot_lut[own_id]);

  always_comb begin
    cls_item.op          = in_operation;
    cls_item.level       = in_button_level;
    cls_item.pairing     = in_pairing_active;
    cls_item.preamble_ok = (in_rx_preamble == TAP_PREAMBLE);
    cls_item.slot        = (in_operation == OP_RX) ? DEV_W'(slot_lut[in_rx_device])
                                                   : own_slot;
    cls_item.rx_sequence = in_rx_sequence;
    cls_item.rx_pattern  = in_rx_pattern;
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ head_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, head_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/trpr_back.sv =====
// ----------------------------------------------------------------------------
// trpr_back
// Sequence table, record/playback state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trpr_back
  import trpr_pkg::*;
#(
  parameter int PATTERN_LEN = PATTERN_LEN_DEF,
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire item_t            head_item,
  output logic                  head_pop,
  input  wire seq_wr_t          cfg_wr,
  input  wire logic [DEV_W-1:0] own_id,
  input  wire logic [PWM_W-1:0] pwm_on,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PWM_W-1:0]      out_pwm_compare,
  output logic                  out_led_on,
  output logic                  out_packet_ready,
  output logic [DEV_W-1:0]      out_tx_device,
  output logic [SEQ_W-1:0]      out_tx_sequence,
  output logic [PAT_W-1:0]      out_tx_pattern,
  output logic                  out_rx_accepted
);

  localparam int SLOT_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int IDX_W  = $clog2(PATTERN_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PATTERN_LEN);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // sequence table; entries never written read as zero
  logic [SEQ_W-1:0] mem [NUM_DEVICES];
  logic             vld_r [NUM_DEVICES];

  // execute stage
  logic             b_valid_r;
  item_t            b_item_r;
  logic [SEQ_W-1:0] mem_rd_r;
  logic             hit_r;
  logic             fwd_r;
  logic [SEQ_W-1:0] fwd_data_r;
  logic [SEQ_W-1:0] seq_cur;
  logic             fire;

  // record / playback state
  logic             rec_active_r, rec_active_nxt;
  logic [IDX_W-1:0] rec_index_r, rec_index_nxt;
  logic [PAT_W-1:0] rec_bits_r, rec_bits_nxt;
  logic             play_active_r, play_active_nxt;
  logic [IDX_W-1:0] play_index_r, play_index_nxt;
  logic [PAT_W-1:0] play_bits_r, play_bits_nxt;
  logic [PWM_W-1:0] pwm_r, pwm_nxt;
  logic             led_r, led_nxt;

  // table write
  logic              tw_en;
  logic [SEQ_W-1:0]  tw_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [SEQ_W-1:0]  wr_data;
  logic [SLOT_W-1:0] rd_addr;

  // result
  logic             pkt;
  logic [SEQ_W-1:0] tx_seq;
  logic [PAT_W-1:0] tx_pat;
  logic             accepted;
  logic [PAT_IDX_W-1:0] play_sh, rec_sh;

  logic             out_valid_r;
  logic [PWM_W-1:0] o_pwm_r;
  logic             o_led_r;
  logic             o_pkt_r;
  logic [DEV_W-1:0] o_dev_r;
  logic [SEQ_W-1:0] o_seq_r;
  logic [PAT_W-1:0] o_pat_r;
  logic             o_acc_r;

  assign fire     = b_valid_r && (!out_valid_r || out_ready);
  assign head_pop = head_valid && (!b_valid_r || fire);
  assign rd_addr  = head_item.slot[SLOT_W-1:0];
  assign seq_cur  = fwd_r ? fwd_data_r : (hit_r ? mem_rd_r : '0);

  // --- execute ---
  always_comb begin
    rec_active_nxt  = rec_active_r;
    rec_index_nxt   = rec_index_r;
    rec_bits_nxt    = rec_bits_r;
    play_active_nxt = play_active_r;
    play_index_nxt  = play_index_r;
    play_bits_nxt   = play_bits_r;
    pwm_nxt         = pwm_r;
    led_nxt         = led_r;
    pkt             = 1'b0;
    tx_seq          = '0;
    tx_pat          = '0;
    accepted        = 1'b0;
    tw_en           = 1'b0;
    tw_data         = '0;
    play_sh         = PAT_IDX_W'(play_index_r);
    rec_sh          = PAT_IDX_W'(rec_index_r);
    case (b_item_r.op)
      OP_TICK: begin
        // playback advances before recording
        if (play_active_r) begin
          play_index_nxt = play_index_r + IDX_ONE;
          pwm_nxt        = play_bits_r[play_sh] ? pwm_on : '0;
          led_nxt        = play_bits_r[play_sh];
          if (play_index_nxt == IDX_LAST) begin
            play_active_nxt = 1'b0;
            pwm_nxt         = '0;
            led_nxt         = 1'b0;
          end
        end
        if (rec_active_r) begin
          rec_bits_nxt[rec_sh] = rec_bits_r[rec_sh] | b_item_r.level;
          rec_index_nxt        = rec_index_r + IDX_ONE;
          if (rec_index_nxt == IDX_LAST) begin
            tw_en          = 1'b1;
            tw_data        = seq_cur + SEQ_W'(1);
            pkt            = 1'b1;
            tx_seq         = tw_data;
            // packet carries the pattern including the last bit
            tx_pat         = rec_bits_nxt;
            rec_active_nxt = 1'b0;
            if (b_item_r.level) begin
              rec_active_nxt = 1'b1;
              rec_index_nxt  = IDX_ONE;
              rec_bits_nxt   = PAT_W'(1);
            end
          end
        end
      end
      OP_PRESS: begin
        if (!rec_active_r && !b_item_r.pairing) begin
          rec_active_nxt = 1'b1;
          rec_index_nxt  = IDX_ONE;
          rec_bits_nxt   = PAT_W'(1);
        end
      end
      OP_RX: begin
        if (b_item_r.preamble_ok && (b_item_r.rx_sequence > seq_cur)) begin
          play_bits_nxt   = b_item_r.rx_pattern;
          play_active_nxt = 1'b1;
          play_index_nxt  = '0;
          tw_en           = 1'b1;
          tw_data         = b_item_r.rx_sequence;
          accepted        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // table write port shared by execute and register writes (a register write wins if both come together)
  always_comb begin
    wr_en   = (fire && tw_en) || cfg_wr.we;
    wr_addr = cfg_wr.we ? cfg_wr.slot[SLOT_W-1:0] : b_item_r.slot[SLOT_W-1:0];
    wr_data = cfg_wr.we ? cfg_wr.data : tw_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // read side bookkeeping, with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (head_pop) begin
      b_item_r   <= head_item;
      hit_r      <= vld_r[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r     <= 1'b0;
      rec_active_r  <= 1'b0;
      rec_index_r   <= '0;
      rec_bits_r    <= '0;
      play_active_r <= 1'b0;
      play_index_r  <= '0;
      play_bits_r   <= '0;
      pwm_r         <= '0;
      led_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (head_pop) begin
        b_valid_r <= 1'b1;
      end else if (fire) begin
        b_valid_r <= 1'b0;
      end
      if (fire) begin
        rec_active_r  <= rec_active_nxt;
        rec_index_r   <= rec_index_nxt;
        rec_bits_r    <= rec_bits_nxt;
        play_active_r <= play_active_nxt;
        play_index_r  <= play_index_nxt;
        play_bits_r   <= play_bits_nxt;
        pwm_r         <= pwm_nxt;
        led_r         <= led_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_pwm_r <= pwm_nxt;
      o_led_r <= led_nxt;
      o_pkt_r <= pkt;
      o_dev_r <= pkt ? own_id : '0;
      o_seq_r <= tx_seq;
      o_pat_r <= tx_pat;
      o_acc_r <= accepted;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_compare  = o_pwm_r;
  assign out_led_on       = o_led_r;
  assign out_packet_ready = o_pkt_r;
  assign out_tx_device    = o_dev_r;
  assign out_tx_sequence  = o_seq_r;
  assign out_tx_pattern   = o_pat_r;
  assign out_rx_accepted  = o_acc_r;

endmodule

`default_nettype wire

// ===== design/tap_pattern_record_replay_unit.sv =====
// ----------------------------------------------------------------------------
// tap_pattern_record_replay_unit
// Records a tap pattern from ticks and button levels, emits finished
// recordings as packets, checks received packets against a per-device
// sequence table and replays accepted patterns onto PWM and LED.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------
//  input    | in_operation .. in_rx_pattern  | in_valid / in_ready
//  result   | out_pwm_compare .. out_rx_acc. | out_valid / out_ready
//  config   | cfg_p* (APB style, 32-bit)     | psel+penable, pready = 1
//
//  One item per clock sustained while out_ready stays high; a result is
//  registered through the queue, the table read and the result register.
//  The per-device table is a 1-write/1-read memory; its read is issued as an
//  item leaves the queue, and a write in the same cycle is bypassed.
//  Reset (sync, active low) empties the pipe and marks all table entries
//  unwritten, which read as zero. No clearing pass is needed.
//  A stalled result register holds the execute stage; the 2-entry queue
//  keeps in_ready high until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_pattern_record_replay_unit
  import trpr_pkg::*;
#(
  parameter int PATTERN_LEN = PATTERN_LEN_DEF,
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input items
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic             in_button_level,
  input  wire logic             in_pairing_active,
  input  wire logic [DEV_W-1:0] in_rx_preamble,
  input  wire logic [DEV_W-1:0] in_rx_device,
  input  wire logic [SEQ_W-1:0] in_rx_sequence,
  input  wire logic [PAT_W-1:0] in_rx_pattern,
  // result items
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PWM_W-1:0]      out_pwm_compare,
  output logic                  out_led_on,
  output logic                  out_packet_ready,
  output logic [DEV_W-1:0]      out_tx_device,
  output logic [SEQ_W-1:0]      out_tx_sequence,
  output logic [PAT_W-1:0]      out_tx_pattern,
  output logic                  out_rx_accepted,
  // register port
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [3:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [DEV_W-1:0] own_id_r;
  logic [PWM_W-1:0] pwm_on_r;
  logic [SEQ_W-1:0] start_seq_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic [DEV_W-1:0] own_slot;
  seq_wr_t          seq_wr;

  logic             head_valid;
  item_t            head_item;
  logic             head_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= DEV_W'(1);
      pwm_on_r    <= '1;
      start_seq_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OWN_ID:    own_id_r    <= cfg_pwdata[DEV_W-1:0];
        REG_PWM_ON:    pwm_on_r    <= cfg_pwdata[PWM_W-1:0];
        REG_START_SEQ: start_seq_r <= cfg_pwdata[SEQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OWN_ID:    cfg_prdata = 32'(own_id_r);
      REG_PWM_ON:    cfg_prdata = 32'(pwm_on_r);
      REG_START_SEQ: cfg_prdata = start_seq_r;
      default:       cfg_prdata = '0;
    endcase
  end

  // writing start_sequence also loads the own table entry
  always_comb begin
    seq_wr.we   = cfg_wr && (cfg_idx == REG_START_SEQ);
    seq_wr.slot = own_slot;
    seq_wr.data = cfg_pwdata[SEQ_W-1:0];
  end

  trpr_front #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_button_level   (in_button_level),
    .in_pairing_active (in_pairing_active),
    .in_rx_preamble    (in_rx_preamble),
    .in_rx_device      (in_rx_device),
    .in_rx_sequence    (in_rx_sequence),
    .in_rx_pattern     (in_rx_pattern),
    .own_id            (own_id_r),
    .own_slot          (own_slot),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .head_pop          (head_pop)
  );

  trpr_back #(
    .PATTERN_LEN (PATTERN_LEN),
    .NUM_DEVICES (NUM_DEVICES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .head_pop         (head_pop),
    .cfg_wr           (seq_wr),
    .own_id           (own_id_r),
    .pwm_on           (pwm_on_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pwm_compare  (out_pwm_compare),
    .out_led_on       (out_led_on),
    .out_packet_ready (out_packet_ready),
    .out_tx_device    (out_tx_device),
    .out_tx_sequence  (out_tx_sequence),
    .out_tx_pattern   (out_tx_pattern),
    .out_rx_accepted  (out_rx_accepted)
  );

endmodule

`default_nettype wire

// ===== test/tap_pattern_record_replay_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tap_pattern_record_replay_unit_tb
// Self-checking bench for the tap record/replay unit. A ledger class keeps
// its own copy of the recorder, the playback shifter and the per-device
// sequence table, predicts one result per accepted item and checks every
// result field. A directed opening is followed by random tick runs, full
// playbacks and mixed traffic under four register settings, with random
// idling on both handshakes.
// ----------------------------------------------------------------------------

module tap_pattern_record_replay_unit_tb;
  import trpr_pkg::*;

  // op code the block leaves unused; it must change nothing
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASE_ITEMS    = 80;    // random items per register setting
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

  // one input item, one result item
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             level;
    logic             pairing;
    logic [DEV_W-1:0] preamble;
    logic [DEV_W-1:0] dev;
    logic [SEQ_W-1:0] seq_no;
    logic [PAT_W-1:0] pat;
  } tap_item_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic             led;
    logic             pkt;
    logic [DEV_W-1:0] tx_dev;
    logic [SEQ_W-1:0] tx_seq;
    logic [PAT_W-1:0] tx_pat;
    logic             acc;
  } tap_result_t;

  // kinds of generated item
  typedef enum int {
    GEN_TICK,
    GEN_PRESS,
    GEN_RX_FRESH,
    GEN_RX_ANY,
    GEN_UNUSED_OP
  } gen_kind_t;

  // --------------------------------------------------------------------------
  // Ledger: mirror of the unit's state and registers, plus the queue of
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class tap_result_ledger;
    logic [DEV_W-1:0] own_id;
    logic [PWM_W-1:0] pwm_on;
    bit               rec_on, play_on, led_now;
    logic [6:0]       rec_pos, play_pos;
    logic [PAT_W-1:0] rec_word, play_word;
    logic [PWM_W-1:0] pwm_now;
    logic [SEQ_W-1:0] seq_tab [256];
    tap_result_t      owed_results [$];
    int               bad_fields, checked;

    function new();
      own_id = 8'd1;
      pwm_on = 16'hFFFF;
      rec_on = 1'b0;
      play_on = 1'b0;
      led_now = 1'b0;
      rec_pos = '0;
      play_pos = '0;
      rec_word = '0;
      play_word = '0;
      pwm_now = '0;
      foreach (seq_tab[i]) seq_tab[i] = '0;
      bad_fields = 0;
      checked = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_OWN_ID: own_id = val[DEV_W-1:0];
        REG_PWM_ON: pwm_on = val[PWM_W-1:0];
        // start value lands in the entry of the current own id
        REG_START_SEQ: seq_tab[own_id] = val;
        default: ;
      endcase
    endfunction

    function void start_recording();
      rec_on = 1'b1;
      rec_pos = 7'd1;
      rec_word = 64'd1;
    endfunction

    function void take_item(tap_item_t it);
      tap_result_t r;
      logic        bit_now;
      r = '0;
      case (it.op)
        OP_TICK: begin
          // playback moves first, then the recorder
          if (play_on) begin
            bit_now = play_word[play_pos[5:0]];
            play_pos = play_pos + 7'd1;
            pwm_now = bit_now ? pwm_on : '0;
            led_now = bit_now;
            if (play_pos >= PATTERN_LEN_DEF) begin
              play_on = 1'b0;
              pwm_now = '0;
              led_now = 1'b0;
            end
          end
          if (rec_on) begin
            if (it.level) rec_word[rec_pos[5:0]] = 1'b1;
            rec_pos = rec_pos + 7'd1;
            if (rec_pos >= PATTERN_LEN_DEF) begin
              seq_tab[own_id] = seq_tab[own_id] + 32'd1;
              r.pkt = 1'b1;
              r.tx_dev = own_id;
              r.tx_seq = seq_tab[own_id];
              r.tx_pat = rec_word;
              rec_on = 1'b0;
              if (it.level) start_recording();
            end
          end
        end
        OP_PRESS: begin
          if (!rec_on && !it.pairing) start_recording();
        end
        OP_RX: begin
          if (it.preamble == TAP_PREAMBLE && it.seq_no > seq_tab[it.dev]) begin
            play_word = it.pat;
            play_on = 1'b1;
            play_pos = '0;
            seq_tab[it.dev] = it.seq_no;
            r.acc = 1'b1;
          end
        end
        default: ;
      endcase
      r.pwm = pwm_now;
      r.led = led_now;
      owed_results.push_back(r);
    endfunction

    function void flag_field(string what, logic [63:0] want, logic [63:0] got);
      bad_fields++;
      if (bad_fields <= 10)
        $display("result %0d: %s expected %0h, got %0h", checked, what, want, got);
    endfunction

    function void match_result(tap_result_t got);
      tap_result_t want;
      checked++;
      if (owed_results.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10) $display("result %0d: arrived with nothing owed", checked);
      end else begin
        want = owed_results.pop_front();
        if (got.pwm !== want.pwm)
          flag_field("pwm_compare", 64'(want.pwm), 64'(got.pwm));
        if (got.led !== want.led)
          flag_field("led_on", 64'(want.led), 64'(got.led));
        if (got.pkt !== want.pkt)
          flag_field("packet_ready", 64'(want.pkt), 64'(got.pkt));
        if (got.tx_dev !== want.tx_dev)
          flag_field("tx_device", 64'(want.tx_dev), 64'(got.tx_dev));
        if (got.tx_seq !== want.tx_seq)
          flag_field("tx_sequence", 64'(want.tx_seq), 64'(got.tx_seq));
        if (got.tx_pat !== want.tx_pat)
          flag_field("tx_pattern", want.tx_pat, got.tx_pat);
        if (got.acc !== want.acc)
          flag_field("rx_accepted", 64'(want.acc), 64'(got.acc));
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation = OP_TICK;
  logic             in_button_level = 1'b0;
  logic             in_pairing_active = 1'b0;
  logic [DEV_W-1:0] in_rx_preamble = '0;
  logic [DEV_W-1:0] in_rx_device = '0;
  logic [SEQ_W-1:0] in_rx_sequence = '0;
  logic [PAT_W-1:0] in_rx_pattern = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PWM_W-1:0] out_pwm_compare;
  logic             out_led_on;
  logic             out_packet_ready;
  logic [DEV_W-1:0] out_tx_device;
  logic [SEQ_W-1:0] out_tx_sequence;
  logic [PAT_W-1:0] out_tx_pattern;
  logic             out_rx_accepted;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [3:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  tap_result_ledger ledger = new();

  int items_sent, packets_seen, accepts_seen;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tap_pattern_record_replay_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_button_level   (in_button_level),
    .in_pairing_active (in_pairing_active),
    .in_rx_preamble    (in_rx_preamble),
    .in_rx_device      (in_rx_device),
    .in_rx_sequence    (in_rx_sequence),
    .in_rx_pattern     (in_rx_pattern),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_compare   (out_pwm_compare),
    .out_led_on        (out_led_on),
    .out_packet_ready  (out_packet_ready),
    .out_tx_device     (out_tx_device),
    .out_tx_sequence   (out_tx_sequence),
    .out_tx_pattern    (out_tx_pattern),
    .out_rx_accepted   (out_rx_accepted),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Helpers. All tasks are entered and left right after a rising edge;
  // handshakes are judged on the values seen at that edge (pre-update).
  // --------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic tap_item_t spell_item(logic [OP_W-1:0] op, logic level,
                                           logic pairing, logic [DEV_W-1:0] pre,
                                           logic [DEV_W-1:0] dev, logic [SEQ_W-1:0] sq,
                                           logic [PAT_W-1:0] pat);
    tap_item_t it;
    it = '{op: op, level: level, pairing: pairing, preamble: pre, dev: dev,
           seq_no: sq, pat: pat};
    return it;
  endfunction

  // random item of the given kind; fields the op ignores carry noise too
  function automatic tap_item_t make_item(gen_kind_t kind);
    tap_item_t        it;
    logic [SEQ_W-1:0] stored;
    it = spell_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                    {$urandom, $urandom});
    case (kind)
      GEN_TICK: it.op = OP_TICK;
      GEN_PRESS: it.op = OP_PRESS;
      GEN_RX_FRESH: begin
        // good preamble, sequence just above what the table holds
        it.op = OP_RX;
        it.preamble = TAP_PREAMBLE;
        if ($urandom_range(0, 3) == 0) it.dev = ledger.own_id;
        stored = ledger.seq_tab[it.dev];
        if (stored < 32'hFFFF_F000) it.seq_no = stored + $urandom_range(1, 300);
      end
      GEN_RX_ANY: begin
        it.op = OP_RX;
        if ($urandom_range(0, 1) == 1) it.preamble = TAP_PREAMBLE;
        // equal sequence: a replay that must be dropped
        if ($urandom_range(0, 2) == 0) it.seq_no = ledger.seq_tab[it.dev];
      end
      default: it.op = OP_UNUSED;
    endcase
    return it;
  endfunction

  // present one item and hold it until taken; the ledger notes it then
  task automatic send_item(input tap_item_t it, input bit calm);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= it.op;
    in_button_level   <= it.level;
    in_pairing_active <= it.pairing;
    in_rx_preamble    <= it.preamble;
    in_rx_device      <= it.dev;
    in_rx_sequence    <= it.seq_no;
    in_rx_pattern     <= it.pat;
    do @(posedge clk); while (!in_ready);
    ledger.take_item(it);
    items_sent++;
  endtask

  // setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ledger.set_register(idx, val);
  endtask

  // drain: stop sending, wait for every owed result, then a few cycles more
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure with calm stretches
  // --------------------------------------------------------------------------
  initial begin
    int          stall;
    bit          calm;
    tap_result_t got;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap(calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.pwm    = out_pwm_compare;
      got.led    = out_led_on;
      got.pkt    = out_packet_ready;
      got.tx_dev = out_tx_device;
      got.tx_seq = out_tx_sequence;
      got.tx_pat = out_tx_pattern;
      got.acc    = out_rx_accepted;
      ledger.match_result(got);
      if (got.pkt === 1'b1) packets_seen++;
      if (got.acc === 1'b1) accepts_seen++;
      if ($urandom_range(0, 19) == 0) calm = !calm;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake on any port restarts the count
  // --------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
        idle = 0;
      else
        idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    tap_item_t opening [$];
    tap_item_t it;
    int        ph, n, k, r, mode, seg_len;
    bit        calm;

    items_sent = 0;
    packets_seen = 0;
    accepts_seen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset register values (own id 1, full PWM, start 0).
    // unused op with every field high
    opening.push_back(spell_item(OP_UNUSED, 1'b1, 1'b1, 8'hFF, 8'hFF, '1, '1));
    // tick with nothing running
    opening.push_back(spell_item(OP_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
    // wrong preamble, highest sequence
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE ^ 8'h01, 8'd3, '1, '1));
    // sequence not above a cleared entry
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE, 8'd0, 32'd0, 64'h1234));
    // fresh packet, pattern with only the end bits set
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE, 8'd0, 32'd1,
                                 64'h8000_0000_0000_0001));
    opening.push_back(spell_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, '0));
    opening.push_back(spell_item(OP_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
    // top device, top sequence restarts playback; the repeat is stale
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE, 8'hFF, '1, '1));
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE, 8'hFF, '1, '0));
    // packet from our own id moves the own sequence
    opening.push_back(spell_item(OP_RX, 1'b0, 1'b0, TAP_PREAMBLE, 8'd1, 32'd7,
                                 64'hAAAA_AAAA_AAAA_AAAA));
    // press during pairing, then a real start, then a press while recording
    opening.push_back(spell_item(OP_PRESS, 1'b0, 1'b1, '0, '0, '0, '0));
    opening.push_back(spell_item(OP_PRESS, 1'b0, 1'b0, '0, '0, '0, '0));
    opening.push_back(spell_item(OP_PRESS, 1'b1, 1'b0, '0, '0, '0, '0));
    // playback and recording on the same tick
    opening.push_back(spell_item(OP_TICK, 1'b0, 1'b0, '0, '0, '0, '0));
    opening.push_back(spell_item(OP_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
    // equal sequence on device 0
    opening.push_back(spell_item(OP_RX, 1'b1, 1'b1, TAP_PREAMBLE, 8'd0, 32'd1, '1));
    opening.push_back(spell_item(OP_UNUSED, 1'b0, 1'b0, '0, '0, '0, '0));
    opening.push_back(spell_item(OP_TICK, 1'b0, 1'b1, 8'hFF, 8'hFF, '1, '1));
    opening.push_back(spell_item(OP_RX, 1'b1, 1'b0, 8'h00, 8'd0, '1, '1));
    foreach (opening[i]) send_item(opening[i], 1'b0);
    wait_quiet();

    // Random phases. The recorder is left running across settings on purpose.
    for (ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          // own sequence at the top: the next packet wraps to zero
          write_reg(REG_OWN_ID, 32'd0);
          write_reg(REG_PWM_ON, 32'd0);
          write_reg(REG_START_SEQ, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_OWN_ID, 32'd255);
          write_reg(REG_PWM_ON, 32'hFFFF);
          write_reg(REG_START_SEQ, 32'd0);
        end
        3: begin
          write_reg(REG_OWN_ID, $urandom_range(1, 254));
          write_reg(REG_PWM_ON, $urandom_range(1, 65534));
          write_reg(REG_START_SEQ, $urandom);
        end
        default: begin
          // id only: the table entries stay where they are
          write_reg(REG_OWN_ID, $urandom_range(0, 255));
        end
      endcase

      n = 0;
      while (n < PHASE_ITEMS) begin
        mode = $urandom_range(0, 99);
        calm = ($urandom_range(0, 3) == 0);
        if (mode < 35) begin
          // press, fresh packet, then 63 to 68 ticks, mostly enough for the playback to end
          send_item(make_item(GEN_PRESS), calm);
          send_item(make_item(GEN_RX_FRESH), calm);
          seg_len = $urandom_range(63, 68);
          repeat (seg_len) send_item(make_item(GEN_TICK), calm);
          n += seg_len + 2;
        end else if (mode < 75) begin
          // long tick run, the odd press or stray packet
          seg_len = $urandom_range(20, 80);
          for (k = 0; k < seg_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 88) it = make_item(GEN_TICK);
            else if (r < 94) it = make_item(GEN_PRESS);
            else if (r < 98) it = make_item(GEN_RX_ANY);
            else it = make_item(GEN_UNUSED_OP);
            send_item(it, calm);
          end
          n += seg_len;
        end else begin
          // short burst of mixed traffic and noise
          seg_len = $urandom_range(4, 16);
          for (k = 0; k < seg_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) it = make_item(GEN_TICK);
            else if (r < 55) it = make_item(GEN_PRESS);
            else if (r < 80) it = make_item(GEN_RX_FRESH);
            else if (r < 95) it = make_item(GEN_RX_ANY);
            else it = make_item(GEN_UNUSED_OP);
            send_item(it, calm);
          end
          n += seg_len;
        end
      end
      wait_quiet();
    end

    $display("Covered %0d items over the reset setting and 4 register settings.", items_sent);
    $display("Checked %0d results: %0d packets emitted, %0d received packets replayed.",
             ledger.checked, packets_seen, accepts_seen);
    if (ledger.bad_fields == 0 && ledger.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== tap_pattern_record_replay_unit.f =====
design/trpr_pkg.sv
design/trpr_front.sv
design/trpr_back.sv
design/tap_pattern_record_replay_unit.sv
test/tap_pattern_record_replay_unit_tb.sv
